// ===== sv/dgdi_pkg.sv =====
// dgdi_pkg: shared constants, types and codes for the delayed gyro delta integrator
// used by every module of the block; depends on nothing
package dgdi_pkg;

   // delay ring
   localparam int DELAY_DEPTH = 80;
   localparam int RING_AW     = $clog2(DELAY_DEPTH);
   localparam int LANES       = 3;

   // fixed-point constants
   localparam logic [30:0] GAIN_Q40     = 31'd1171306380;
   localparam logic [31:0] PERIOD_RESET = 32'd536871;
   localparam logic [23:0] COUNT_MAX    = 24'hFF_FFFF;
   localparam logic [47:0] PSUM_MAX     = 48'hFFFF_FFFF_FFFF;
   localparam logic [32:0] INTERVAL_RESET = 33'd214748365;
   localparam logic [19:0] TICK_RESET     = 20'd10000;

   // shared divider geometry, two quotient bits per cycle
   localparam int DIV_NW    = 66;
   localparam int DIV_DW    = 44;
   localparam int DIV_STEPS = DIV_NW / 2;
   localparam int DIV_CW    = $clog2(DIV_STEPS);

   // register indexes
   localparam logic [0:0] CSR_EMIT_SPACING = 1'd0;
   localparam logic [0:0] CSR_TICK_RATE    = 1'd1;

   // lane control from the sequencer
   typedef struct packed {
      logic add;
      logic start;
   } lane_ctl_type;

endpackage

// ===== sv/dgdi_div.sv =====
// dgdi_div: restoring unsigned divider, two quotient bits per cycle
// uses dgdi_pkg for its widths
module dgdi_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dgdi_pkg::DIV_NW-1:0]   num,
   input  logic [dgdi_pkg::DIV_DW-1:0]   den,
   output logic [dgdi_pkg::DIV_NW-1:0]   quo,
   output logic                          done
);

   logic [dgdi_pkg::DIV_DW-1:0] rem_ff, rem_in;
   logic [dgdi_pkg::DIV_NW-1:0] sh_ff, sh_in;
   logic [dgdi_pkg::DIV_DW-1:0] den_ff;
   logic [dgdi_pkg::DIV_CW-1:0] cnt_ff;
   logic                        run_ff;
   logic                        done_ff;

   // two shift-subtract steps
   always_comb begin
      logic [dgdi_pkg::DIV_DW:0] t;
      rem_in = rem_ff;
      sh_in  = sh_ff;
      for (int i = 0; i < 2; i++) begin
         t     = {rem_in, sh_in[dgdi_pkg::DIV_NW-1]};
         sh_in = {sh_in[dgdi_pkg::DIV_NW-2:0], 1'b0};
         if (t >= {1'b0, den_ff}) begin
            t        = t - {1'b0, den_ff};
            sh_in[0] = 1'b1;
         end
         rem_in = t[dgdi_pkg::DIV_DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff <= '0;
            sh_ff  <= num;
            den_ff <= den;
            cnt_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            rem_ff <= rem_in;
            sh_ff  <= sh_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == dgdi_pkg::DIV_CW'(dgdi_pkg::DIV_STEPS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quo  = sh_ff;
   assign done = done_ff;

endmodule

// ===== sv/dgdi_lane.sv =====
// dgdi_lane: one gyro axis, saturating sum and scaled delta at emission
// uses dgdi_pkg and dgdi_div
module dgdi_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  dgdi_pkg::lane_ctl_type ctl,
   input  logic signed [15:0]    sample,
   input  logic [23:0]           count,
   input  logic [47:0]           psum,
   output logic signed [31:0]    delta,
   output logic                  done
);

   logic signed [39:0] sum_ff;
   logic signed [40:0] sum_wide;
   logic               neg_ff;
   logic [39:0]        mag;
   logic [55:0]        num56;
   logic [dgdi_pkg::DIV_NW-1:0] quo;
   logic               div_done;
   logic [30:0]        mean_ff;
   logic [29:0]        rate_ff;
   logic [61:0]        prod1;
   logic [53:0]        a_ff, b_ff;
   logic [54:0]        r;
   logic [46:0]        q;
   logic [46:0]        lim;
   logic [46:0]        qc;
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [31:0] delta_ff;
   logic               done_ff;

   // saturating add of the delayed sample
   assign sum_wide = 41'(sum_ff) + 41'(sample);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctl.start) begin
         sum_ff <= '0;
      end else if (ctl.add) begin
         if (sum_wide > 41'sd549755813887)
            sum_ff <= 40'sh7F_FFFF_FFFF;
         else if (sum_wide < -41'sd549755813888)
            sum_ff <= 40'sh80_0000_0000;
         else
            sum_ff <= sum_wide[39:0];
      end
   end

   // divider operands: rounded mean of the magnitude
   assign mag   = sum_ff[39] ? 40'(-sum_ff) : 40'(sum_ff);
   assign num56 = {mag, 16'b0} + 56'(count >> 1);

   dgdi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (ctl.start),
      .num   (dgdi_pkg::DIV_NW'(num56)),
      .den   (dgdi_pkg::DIV_DW'(count)),
      .quo   (quo),
      .done  (div_done)
   );

   always_ff @(posedge clock) begin
      if (ctl.start) neg_ff <= sum_ff[39];
   end

   // scaling pipeline after the divide
   assign prod1 = mean_ff * dgdi_pkg::GAIN_Q40;
   assign r     = 55'({a_ff[7:0], 24'b0}) + 55'(b_ff) + 55'h8000_0000;
   assign q     = 47'(a_ff >> 8) + 47'(r >> 32);
   assign lim   = neg_ff ? 47'h8000_0000 : 47'h7FFF_FFFF;
   assign qc    = (q > lim) ? lim : q;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= div_done;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         v4_ff   <= v3_ff;
         done_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (div_done)
         mean_ff <= (quo > dgdi_pkg::DIV_NW'(31'h7FFF_FFFF)) ? 31'h7FFF_FFFF : quo[30:0];
      if (v1_ff) rate_ff <= 30'((62'(prod1) + 62'h8000_0000) >> 32);
      if (v2_ff) a_ff <= rate_ff * psum[47:24];
      if (v3_ff) b_ff <= rate_ff * psum[23:0];
      if (v4_ff) delta_ff <= neg_ff ? 32'(-qc[31:0]) : signed'(qc[31:0]);
   end

   assign delta = delta_ff;
   assign done  = done_ff;

endmodule

// ===== sv/dgdi_adapt.sv =====
// dgdi_adapt: sample period estimate and its adaptation at each emission
// uses dgdi_pkg and dgdi_div
module dgdi_adapt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] now,
   input  logic [23:0] count,
   input  logic [19:0] tick_rate,
   output logic [31:0] estimate,
   output logic        done
);

   typedef enum logic [5:0] {
      A_IDLE  = 6'b000001,
      A_DEN   = 6'b000010,
      A_DIV1  = 6'b000100,
      A_PROD  = 6'b001000,
      A_SDIV2 = 6'b010000,
      A_DIV2  = 6'b100000
   } adapt_state_type;

   adapt_state_type state_ff;
   logic [31:0] est_ff;
   logic [31:0] last_ff;
   logic        first_ff;
   logic        done_ff;
   logic [31:0] e_ff;
   logic [43:0] den_ff;
   logic [32:0] wden_ff;
   logic [31:0] diff_ff;
   logic        up_ff;
   logic [63:0] prod_ff;
   logic [19:0] rate;
   logic [31:0] e_in;
   logic [31:0] meas;
   logic        div_start;
   logic [dgdi_pkg::DIV_NW-1:0] div_num, quo;
   logic [dgdi_pkg::DIV_DW-1:0] div_den;
   logic        div_done;

   assign rate = (tick_rate == '0) ? 20'd1 : tick_rate;
   assign e_in = now - last_ff;
   assign meas = (quo[dgdi_pkg::DIV_NW-1:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];

   // shared divider: measured period, then the weighted step
   assign div_start = (state_ff == A_DEN) || (state_ff == A_SDIV2);
   assign div_num   = (state_ff == A_DEN) ? dgdi_pkg::DIV_NW'({e_ff, 32'b0})
                    : dgdi_pkg::DIV_NW'(prod_ff) + dgdi_pkg::DIV_NW'(wden_ff[32:1]);
   assign div_den   = (state_ff == A_DEN) ? den_ff : dgdi_pkg::DIV_DW'(wden_ff);

   dgdi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (quo),
      .done  (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         est_ff   <= dgdi_pkg::PERIOD_RESET;
         last_ff  <= '0;
         first_ff <= 1'b1;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            A_IDLE: begin
               if (start) begin
                  last_ff  <= now;
                  first_ff <= 1'b0;
                  if (first_ff) begin
                     done_ff <= 1'b1;
                  end else begin
                     e_ff     <= e_in;
                     den_ff   <= rate * count;
                     wden_ff  <= 33'(e_in) + 33'(24'(rate) * 24'd10);
                     state_ff <= A_DEN;
                  end
               end
            end
            A_DEN:   state_ff <= A_DIV1;
            A_DIV1: begin
               if (div_done) begin
                  up_ff    <= meas >= est_ff;
                  diff_ff  <= (meas >= est_ff) ? meas - est_ff : est_ff - meas;
                  state_ff <= A_PROD;
               end
            end
            A_PROD: begin
               prod_ff  <= diff_ff * e_ff;
               state_ff <= A_SDIV2;
            end
            A_SDIV2: state_ff <= A_DIV2;
            A_DIV2: begin
               if (div_done) begin
                  est_ff   <= up_ff ? est_ff + quo[31:0] : est_ff - quo[31:0];
                  done_ff  <= 1'b1;
                  state_ff <= A_IDLE;
               end
            end
            default: state_ff <= A_IDLE;
         endcase
      end
   end

   assign estimate = est_ff;
   assign done     = done_ff;

endmodule

// ===== sv/delayed_gyro_delta_integrator_core.sv =====
// delayed_gyro_delta_integrator_core: top level, delay ring, sequencer and result register
// uses dgdi_pkg, dgdi_lane (three axis lanes) and dgdi_adapt
//
// usage: one req_ beat carries a three-axis gyro sample, a trigger flag and a
// timestamp. the sample is written into an 80-deep delay ring and the sample
// leaving the ring is added to the axis sums in three parallel lanes. when the
// trigger is set and the accumulated period reaches the emit spacing, one rsp_
// beat follows with the three deltas and the interval sum.
// an item that emits nothing passes through the accumulate state and back to
// idle. an emitting item keeps req_stall high until its result is loaded,
// which is set by the two serial divisions of the period adaptation unit;
// the lanes' divide and multiply chain runs beside it. the first emission
// skips the adaptation and waits on the lanes alone.
// the result register holds a beat while rsp_stall is high and new samples
// are still taken; a finished emission waits only while that register holds a stalled beat.
// csr_ writes set the emit spacing (index 0) and the tick rate (index 1).
// reset (synchronous) restores register defaults and the period estimate, clears the
// ring's per-entry valid bits, the sums and counters at once.
module delayed_gyro_delta_integrator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   input  logic signed [15:0] req_gyro_z,
   input  logic               req_trigger,
   input  logic [31:0]        req_timestamp,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_delta_x,
   output logic signed [31:0] rsp_delta_y,
   output logic signed [31:0] rsp_delta_z,
   output logic [47:0]        rsp_interval_sum,
   input  logic               csr_write,
   input  logic [0:0]         csr_index,
   input  logic [32:0]        csr_wdata
);

   typedef enum logic [3:0] {
      T_IDLE  = 4'b0001,
      T_ACC   = 4'b0010,
      T_START = 4'b0100,
      T_WAIT  = 4'b1000
   } top_state_type;

   top_state_type state_ff;
   logic [32:0] interval_ff;
   logic [19:0] tick_ff;

   logic [dgdi_pkg::RING_AW-1:0] head_ff, head_in;
   logic [47:0] ring_mem [dgdi_pkg::DELAY_DEPTH];
   logic [dgdi_pkg::DELAY_DEPTH-1:0] ring_valid_ff;
   logic [47:0] ring_rd_ff;
   logic        ring_rdv_ff;
   logic [47:0] sample_word;

   logic        trig_ff;
   logic [31:0] now_ff;
   logic [23:0] count_ff;
   logic [47:0] psum_ff, psum_in;
   logic [48:0] psum_wide;
   logic [47:0] psum_snap_ff;
   logic        lane_seen_ff, adapt_seen_ff;

   logic        req_accept;
   logic        rsp_free;
   logic        rsp_load;
   logic        result_ready;
   dgdi_pkg::lane_ctl_type lane_ctl;
   logic signed [31:0] lane_delta [dgdi_pkg::LANES];
   logic [dgdi_pkg::LANES-1:0] lane_done;
   logic [31:0] estimate;
   logic        adapt_done;

   logic        rsp_valid_ff;
   logic signed [31:0] rsp_dx_ff, rsp_dy_ff, rsp_dz_ff;
   logic [47:0] rsp_isum_ff;

   assign req_stall  = state_ff != T_IDLE;
   assign req_accept = req_valid && !req_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= dgdi_pkg::INTERVAL_RESET;
         tick_ff     <= dgdi_pkg::TICK_RESET;
      end else if (csr_write) begin
         case (csr_index)
            dgdi_pkg::CSR_EMIT_SPACING: interval_ff <= csr_wdata;
            dgdi_pkg::CSR_TICK_RATE:    tick_ff     <= csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   // delay ring: read the outgoing entry and write the new sample at one address
   assign head_in = (head_ff == dgdi_pkg::RING_AW'(dgdi_pkg::DELAY_DEPTH - 1))
                  ? '0 : head_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ring_rd_ff        <= ring_mem[head_in];
         ring_mem[head_in] <= {req_gyro_z, req_gyro_y, req_gyro_x};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_valid_ff <= '0;
         ring_rdv_ff   <= 1'b0;
         head_ff       <= '0;
      end else if (req_accept) begin
         ring_rdv_ff            <= ring_valid_ff[head_in];
         ring_valid_ff[head_in] <= 1'b1;
         head_ff                <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         trig_ff <= req_trigger;
         now_ff  <= req_timestamp;
      end
   end

   assign sample_word = ring_rdv_ff ? ring_rd_ff : '0;

   // period sum with saturation
   assign psum_wide = {1'b0, psum_ff} + 49'(estimate);
   assign psum_in   = psum_wide[48] ? dgdi_pkg::PSUM_MAX : psum_wide[47:0];

   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign result_ready = (lane_seen_ff || lane_done[0]) && (adapt_seen_ff || adapt_done);
   assign rsp_load     = (state_ff == T_WAIT) && result_ready && rsp_free;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         count_ff      <= '0;
         psum_ff       <= '0;
         lane_seen_ff  <= 1'b0;
         adapt_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !rsp_load) rsp_valid_ff <= 1'b0;
         case (state_ff)
            T_IDLE: begin
               if (req_accept) state_ff <= T_ACC;
            end
            T_ACC: begin
               psum_ff  <= psum_in;
               count_ff <= (count_ff == dgdi_pkg::COUNT_MAX) ? count_ff : count_ff + 1'b1;
               state_ff <= (trig_ff && (psum_in >= 48'(interval_ff))) ? T_START : T_IDLE;
            end
            T_START: begin
               psum_snap_ff  <= psum_ff;
               psum_ff       <= '0;
               count_ff      <= '0;
               lane_seen_ff  <= 1'b0;
               adapt_seen_ff <= 1'b0;
               state_ff      <= T_WAIT;
            end
            T_WAIT: begin
               if (lane_done[0]) lane_seen_ff  <= 1'b1;
               if (adapt_done)   adapt_seen_ff <= 1'b1;
               if (rsp_load) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= T_IDLE;
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_dx_ff   <= lane_delta[0];
         rsp_dy_ff   <= lane_delta[1];
         rsp_dz_ff   <= lane_delta[2];
         rsp_isum_ff <= psum_snap_ff;
      end
   end

   // axis lanes
   assign lane_ctl.add   = state_ff == T_ACC;
   assign lane_ctl.start = state_ff == T_START;

   for (genvar g = 0; g < dgdi_pkg::LANES; g++) begin : g_lane
      dgdi_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (lane_ctl),
         .sample (signed'(sample_word[g*16 +: 16])),
         .count  (count_ff),
         .psum   (psum_snap_ff),
         .delta  (lane_delta[g]),
         .done   (lane_done[g])
      );
   end

   dgdi_adapt u_adapt (
      .clock     (clock),
      .reset     (reset),
      .start     (state_ff == T_START),
      .now       (now_ff),
      .count     (count_ff),
      .tick_rate (tick_ff),
      .estimate  (estimate),
      .done      (adapt_done)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_delta_x      = rsp_dx_ff;
   assign rsp_delta_y      = rsp_dy_ff;
   assign rsp_delta_z      = rsp_dz_ff;
   assign rsp_interval_sum = rsp_isum_ff;

   // lanes run in lock step
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      (lane_done[0] == lane_done[1]) && (lane_done[1] == lane_done[2]))
      else $error("axis lanes out of step");

   // lane results arrive only while an emission is pending
   a_lane_done_wait: assert property (@(posedge clock) disable iff (reset)
      lane_done[0] |-> (state_ff == T_WAIT))
      else $error("lane result outside emission");

   // an emission start clears the count and the period sum
   a_clear_after_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_START) |=> (count_ff == '0) && (psum_ff == '0))
      else $error("emission did not clear accumulators");

   // a result is only loaded with both units finished
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == T_WAIT) && !result_ready) |=> !$rose(rsp_valid_ff))
      else $error("result loaded early");

endmodule
